/* rtl/core/lrufr_pkg.sv */
`timescale 1ns / 1ps

package lrufr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_W      = 16;
    localparam int IDX_OUT_W   = 3;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 4;
    localparam int OUT_FIELD_W = 1 + IDX_OUT_W + 1 + PAGE_W + CNT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [CFG_W-1:0] FIU_RESET = CFG_W'(8);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic upd;
        logic commit;
    } lrufr_cmd_t;

    typedef struct packed {
        logic out_free;
    } lrufr_status_t;

endpackage

/* rtl/core/lrufr_ctrl.sv */
`timescale 1ns / 1ps

module lrufr_ctrl #(
    parameter int FRAMES = 8,
    parameter int IDX_W  = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [lrufr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    output lrufr_pkg::lrufr_cmd_t        cmd,
    output logic [IDX_W-1:0]             rd_addr,
    input  lrufr_pkg::lrufr_status_t     status
);
    import lrufr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SWAIT = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_UWAIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] ctr_reg, ctr_next;
    logic [CFG_W-1:0] fiu_reg;
    logic [31:0]      fiu_wide;
    logic [IDX_W-1:0] last_idx;

    // The frame count saturates to the range one to FRAMES.
    always_comb
    begin
        fiu_wide = 32'(fiu_reg);
        priority if (fiu_wide == 32'd0)
        begin
            last_idx = '0;
        end
        else if (fiu_wide > 32'(FRAMES))
        begin
            last_idx = IDX_W'(FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'(fiu_wide - 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= FIU_RESET;
        end
        else if (cfg_wr_en)
        begin
            fiu_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    ctr_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (ctr_reg == last_idx)
                begin
                    state_next = ST_SWAIT;
                end
                else
                begin
                    ctr_next = ctr_reg + IDX_W'(1);
                end
            end
            ST_SWAIT:
            begin
                ctr_next   = '0;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.rd_en = 1'b1;
                cmd.upd   = 1'b1;
                if (ctr_reg == last_idx)
                begin
                    state_next = ST_UWAIT;
                end
                else
                begin
                    ctr_next = ctr_reg + IDX_W'(1);
                end
            end
            ST_UWAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
        end
    end

endmodule

/* rtl/core/lrufr_dp.sv */
`timescale 1ns / 1ps

module lrufr_dp #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lrufr_pkg::PAGE_W-1:0]       s_page,
    input  lrufr_pkg::lrufr_cmd_t              cmd,
    input  logic [IDX_W-1:0]                   rd_addr,
    output lrufr_pkg::lrufr_status_t           status,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic [lrufr_pkg::OUT_TDATA_W-1:0]  m_data
);
    import lrufr_pkg::*;

    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [RANK_W-1:0]    rank_mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [RANK_W-1:0]    rd_rank_reg;

    logic                 d_en_reg, d_upd_reg;
    logic [IDX_W-1:0]     d_addr_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [PAGE_BITS-1:0] page_in_reg;
    logic [31:0]          page_wide;

    logic                 hit_found_reg, empty_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg, empty_idx_reg, best_idx_reg;
    logic [RANK_W-1:0]    hit_rank_reg, best_rank_reg;
    logic [PAGE_BITS-1:0] best_page_reg;

    logic [CNT_W-1:0]     hits_reg, faults_reg, hits_next, faults_next;

    logic                 out_valid_reg, out_hit_reg, out_ev_valid_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [PAGE_W-1:0]    out_ev_page_reg;
    logic [CNT_W-1:0]     out_hits_reg, out_faults_reg;

    logic                 valid_i, scan_act, upd_act, is_f, inc;
    logic                 use_empty, evict;
    logic [IDX_W-1:0]     f_idx;
    logic [RANK_W-1:0]    old_rank;
    logic                 wr_en;
    logic [PAGE_BITS-1:0] wr_page;
    logic [RANK_W-1:0]    wr_rank;
    logic [31:0]          f_wide, ev_wide;

    assign page_wide = 32'(s_page);
    assign valid_i   = valid_reg[d_addr_reg];
    assign scan_act  = d_en_reg && !d_upd_reg;
    assign upd_act   = d_en_reg && d_upd_reg;

    // An empty victim counts as older than every resident frame, so all of them age.
    assign use_empty = !hit_found_reg && empty_found_reg;
    assign evict     = !hit_found_reg && !empty_found_reg;
    assign f_idx     = hit_found_reg ? hit_idx_reg : (empty_found_reg ? empty_idx_reg : best_idx_reg);
    assign old_rank  = hit_found_reg ? hit_rank_reg : best_rank_reg;

    assign is_f    = d_addr_reg == f_idx;
    assign inc     = valid_i && (use_empty || rd_rank_reg < old_rank) && rd_rank_reg < RANK_MAX;
    assign wr_en   = upd_act && (is_f || inc);
    assign wr_page = is_f ? page_in_reg : rd_page_reg;
    assign wr_rank = is_f ? '0 : rd_rank_reg + RANK_W'(1);

    assign hits_next   = (hit_found_reg && hits_reg != CNT_MAX) ? hits_reg + CNT_W'(1) : hits_reg;
    assign faults_next = (!hit_found_reg && faults_reg != CNT_MAX) ?
                         faults_reg + CNT_W'(1) : faults_reg;
    assign f_wide      = 32'(f_idx);
    assign ev_wide     = 32'(best_page_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[d_addr_reg] <= wr_page;
            rank_mem[d_addr_reg] <= wr_rank;
        end
        if (cmd.rd_en)
        begin
            rd_page_reg <= page_mem[rd_addr];
            rd_rank_reg <= rank_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        d_addr_reg <= rd_addr;
        if (cmd.load)
        begin
            page_in_reg <= page_wide[PAGE_BITS-1:0];
        end
        if (scan_act)
        begin
            if (!hit_found_reg && valid_i && rd_page_reg == page_in_reg)
            begin
                hit_idx_reg  <= d_addr_reg;
                hit_rank_reg <= rd_rank_reg;
            end
            if (!empty_found_reg && !valid_i)
            begin
                empty_idx_reg <= d_addr_reg;
            end
            // The lowest-indexed frame with the largest rank wins a tie.
            if (d_addr_reg == '0 || rd_rank_reg > best_rank_reg)
            begin
                best_idx_reg  <= d_addr_reg;
                best_rank_reg <= rd_rank_reg;
                best_page_reg <= rd_page_reg;
            end
        end
        if (cmd.commit)
        begin
            out_hit_reg      <= hit_found_reg;
            out_idx_reg      <= f_wide[IDX_OUT_W-1:0];
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= evict ? ev_wide[PAGE_W-1:0] : '0;
            out_hits_reg     <= hits_next;
            out_faults_reg   <= faults_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_en_reg        <= 1'b0;
            d_upd_reg       <= 1'b0;
            valid_reg       <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            hits_reg        <= '0;
            faults_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            d_en_reg  <= cmd.rd_en;
            d_upd_reg <= cmd.upd;
            if (cmd.load)
            begin
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
            end
            else if (scan_act)
            begin
                if (valid_i && rd_page_reg == page_in_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!valid_i)
                begin
                    empty_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg[f_idx] <= 1'b1;
                hits_reg         <= hits_next;
                faults_reg       <= faults_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = {{OUT_PAD_W{1'b0}}, out_faults_reg, out_hits_reg, out_ev_page_reg,
                      out_ev_valid_reg, out_idx_reg, out_hit_reg};

endmodule

/* rtl/core/lru_frame_replacement.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                     Words
// s_axis    in         tvalid tready tdata[15:0] one page reference
// m_axis    out        tvalid tready tdata[87:0] one result per reference
// cfg       in         cfg_wr_en cfg_wr_data[3:0] frames in use
//
// An item runs through the scan, scan-wait, update, update-wait and done states from acceptance to the next ready.
// The frame table is read once to search and once to update the ranks.
// Reset clears the valid bits, the counters and the control; no clearing pass is needed.
// A stalled result waits in the output register while the next reference is taken.
// The following result then holds in the done state until that register is free.

module lru_frame_replacement #(
    parameter int FRAMES    = lrufr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrufr_pkg::PAGE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lrufr_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // page_number[15:0]
    input  logic [lrufr_pkg::PAGE_W-1:0]       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit[0], frame_index[3:1], evicted_valid[4], evicted_page[20:5],
    // hit_count[52:21], fault_count[84:53], zero fill above
    output logic [lrufr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lrufr_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    lrufr_cmd_t       cmd;
    lrufr_status_t    status;
    logic [IDX_W-1:0] rd_addr;

    lrufr_ctrl #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status)
    );

    lrufr_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_page  (s_axis_tdata),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .status  (status),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_data  (m_axis_tdata)
    );

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed while the output register was occupied");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmd.rd_en && !cmd.commit)
        else $error("frame table access while waiting for a reference");

    a_no_fast_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !cmd.commit && !s_axis_tready)
        else $error("reference finished without a search");

endmodule
